[sv/pfe_pkg.sv]
package pfe_pkg;

  localparam int NUM_COMP = 3;
  localparam int FRAME_BITS = 16;

  typedef enum logic [2:0] {
    CMD_WR_TARGET  = 3'd0,
    CMD_WR_CURRENT = 3'd1,
    CMD_COMMIT     = 3'd2,
    CMD_TICK       = 3'd3,
    CMD_READ       = 3'd4
  } cmd_t;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_LOOK   = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_COPY   = 9'b000010000,
    S_FETCH  = 9'b000100000,
    S_LOAD   = 9'b001000000,
    S_DIVIDE = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

endpackage

[sv/palette_fade_engine.sv]
// Palette fade engine: holds a target and a current palette in two dual-port RAMs and fades
// the current palette toward the target, one frame per tick command.
// Input channel s_*: one transaction carries one command (tuser) with its index, colour and
// frame budget (tdata). Output channel m_*: exactly one result transaction per command,
// carrying read data, the changed flag, the held flag and the frames remaining.
// A frame tick first compares both palettes, one entry a cycle. If they differ, it then
// either copies the target, when no frames are left, or updates every entry through three
// bit-serial dividers. After reset both RAMs are cleared, one entry a cycle; s_tready stays
// low meanwhile. A result waits in the output register while m_tready is low; the next
// command is still accepted, and its own result waits until the register is free.
module palette_fade_engine
  import pfe_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256,
  parameter int COMPONENT_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // entry_index, entry_red, entry_green, entry_blue, frame_budget
  input  logic [47:0] s_tdata,
  // command
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_red, read_green, read_blue, palette_changed, target_held, frames_remaining, zero pad
  output logic [47:0] m_tdata
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CW = AW + 1;
  localparam int CB = COMPONENT_BITS;
  localparam int MW = NUM_COMP * CB;
  localparam int DW = $clog2(CB + 1);

  state_t state;
  cmd_t   cmd;
  logic [AW-1:0] idx;
  logic [CB-1:0] comp [NUM_COMP];
  logic [CW-1:0] cnt;
  logic [AW-1:0] copy_addr;
  logic pend, differs;
  logic [DW-1:0] dcnt;
  logic target_valid, target_modified;
  logic [FRAME_BITS-1:0] frames_left;
  logic [7:0] rd [NUM_COMP];
  logic changed;

  logic [MW-1:0] target_mem [PALETTE_ENTRIES];
  logic [MW-1:0] current_mem [PALETTE_ENTRIES];
  logic [MW-1:0] t_rdata, c_rdata;
  logic [AW-1:0] rd_addr;
  logic t_we, c_we;
  logic [AW-1:0] t_waddr, c_waddr;
  logic [MW-1:0] t_wdata, c_wdata;

  logic [CB-1:0] ucur [NUM_COMP];
  logic [CB-1:0] utgt [NUM_COMP];
  logic [CB-1:0] dq [NUM_COMP];
  logic [16:0]   rem [NUM_COMP];
  logic [MW-1:0] upd_word, comp_word;

  logic accept, in_range, out_load;
  logic [AW-1:0] in_idx;
  cmd_t in_cmd;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);
  assign in_cmd   = cmd_t'(s_tuser);
  assign in_idx   = AW'(s_tdata[7:0]);
  assign in_range = {24'd0, s_tdata[7:0]} < 32'(PALETTE_ENTRIES);

  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      comp_word[c*CB +: CB] = comp[c];
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      logic [CB-1:0] step;
      step = dq[c] + CB'(rem[c] != 17'd0);
      upd_word[c*CB +: CB] = (utgt[c] > ucur[c]) ? ucur[c] + step : ucur[c] - step;
    end
  end

  always_comb begin
    rd_addr = (state == S_IDLE) ? in_idx : cnt[AW-1:0];
    t_we    = 1'b0;
    t_waddr = idx;
    t_wdata = comp_word;
    c_we    = 1'b0;
    c_waddr = idx;
    c_wdata = comp_word;
    case (state)
      S_CLEAR: begin
        t_we = 1'b1;
        t_waddr = cnt[AW-1:0];
        t_wdata = '0;
        c_we = 1'b1;
        c_waddr = cnt[AW-1:0];
        c_wdata = '0;
      end
      S_IDLE: begin
        c_we = accept && in_cmd == CMD_WR_CURRENT && in_range;
        c_waddr = in_idx;
        for (int c = 0; c < NUM_COMP; c++) begin
          c_wdata[c*CB +: CB] = CB'(s_tdata[8 + 8*c +: 8]);
        end
      end
      S_LOOK: begin
        t_we = (cmd == CMD_WR_TARGET) && (t_rdata != comp_word);
      end
      S_COPY: begin
        c_we = pend;
        c_waddr = copy_addr;
        c_wdata = t_rdata;
      end
      S_DIVIDE: begin
        c_we = (dcnt == DW'(CB));
        c_waddr = cnt[AW-1:0];
        c_wdata = upd_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      target_mem[t_waddr] <= t_wdata;
    end
    t_rdata <= target_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      current_mem[c_waddr] <= c_wdata;
    end
    c_rdata <= current_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        ucur[c] <= c_rdata[c*CB +: CB];
        utgt[c] <= t_rdata[c*CB +: CB];
        dq[c] <= (t_rdata[c*CB +: CB] > c_rdata[c*CB +: CB]) ?
                 t_rdata[c*CB +: CB] - c_rdata[c*CB +: CB] :
                 c_rdata[c*CB +: CB] - t_rdata[c*CB +: CB];
        rem[c] <= '0;
      end
    end else if (state == S_DIVIDE && dcnt != DW'(CB)) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        logic [16:0] rs;
        logic ge;
        rs = {rem[c][15:0], dq[c][CB-1]};
        ge = rs >= {1'b0, frames_left};
        rem[c] <= ge ? rs - {1'b0, frames_left} : rs;
        dq[c] <= {dq[c][CB-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= in_cmd;
      idx <= in_idx;
      for (int c = 0; c < NUM_COMP; c++) begin
        comp[c] <= CB'(s_tdata[8 + 8*c +: 8]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      pend <= 1'b0;
      differs <= 1'b0;
      dcnt <= '0;
      copy_addr <= '0;
      target_valid <= 1'b0;
      target_modified <= 1'b0;
      frames_left <= '0;
      changed <= 1'b0;
      m_tvalid <= 1'b0;
      for (int c = 0; c < NUM_COMP; c++) begin
        rd[c] <= '0;
      end
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (cnt == CW'(PALETTE_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
          cnt <= cnt + CW'(1);
        end
        S_IDLE: begin
          if (accept) begin
            changed <= 1'b0;
            cnt <= '0;
            pend <= 1'b0;
            differs <= 1'b0;
            for (int c = 0; c < NUM_COMP; c++) begin
              rd[c] <= '0;
            end
            state <= S_DONE;
            case (in_cmd)
              CMD_WR_TARGET, CMD_READ: begin
                if (in_range) begin
                  state <= S_LOOK;
                end
              end
              CMD_COMMIT: begin
                if (!target_valid || target_modified) begin
                  frames_left <= s_tdata[47:32];
                  target_valid <= 1'b1;
                  target_modified <= 1'b0;
                end
              end
              CMD_TICK: begin
                if (target_valid) begin
                  state <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_LOOK: begin
          if (t_we) begin
            target_modified <= 1'b1;
          end
          if (cmd == CMD_READ) begin
            for (int c = 0; c < NUM_COMP; c++) begin
              rd[c] <= 8'(c_rdata[c*CB +: CB]);
            end
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          pend <= cnt != CW'(PALETTE_ENTRIES);
          if (cnt != CW'(PALETTE_ENTRIES)) begin
            cnt <= cnt + CW'(1);
          end
          if (pend && t_rdata != c_rdata) begin
            differs <= 1'b1;
          end
          if (cnt == CW'(PALETTE_ENTRIES) && !pend) begin
            cnt <= '0;
            if (!differs) begin
              state <= S_DONE;
            end else if (frames_left == '0) begin
              state <= S_COPY;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_COPY: begin
          pend <= cnt != CW'(PALETTE_ENTRIES);
          copy_addr <= cnt[AW-1:0];
          if (cnt != CW'(PALETTE_ENTRIES)) begin
            cnt <= cnt + CW'(1);
          end else if (!pend) begin
            changed <= 1'b1;
            state <= S_DONE;
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          dcnt <= '0;
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (dcnt != DW'(CB)) begin
            dcnt <= dcnt + DW'(1);
          end else begin
            cnt <= cnt + CW'(1);
            if (cnt == CW'(PALETTE_ENTRIES - 1)) begin
              frames_left <= frames_left - FRAME_BITS'(1);
              changed <= 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0, frames_left, target_valid, changed, rd[2], rd[1], rd[0]};
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(state == S_CLEAR))
    else $error("input accepted during clearing pass");

  a_held_sticks: assert property (@(posedge clk) disable iff (rst)
    target_valid |=> target_valid)
    else $error("target held flag fell");

  a_divide_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIVIDE |-> frames_left != '0)
    else $error("division with no frames left");

  a_target_write_place: assert property (@(posedge clk) disable iff (rst)
    t_we |-> (state == S_LOOK || state == S_CLEAR))
    else $error("target written outside a target write");

  a_changed_only_tick: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && changed) |-> cmd == CMD_TICK)
    else $error("change flagged for a command other than a tick");

endmodule

[verif/tb_palette_fade_engine.sv]
`timescale 1ns / 1ps

module tb_palette_fade_engine;
  import pfe_pkg::*;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] budget;
  } fade_cmd_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        changed;
    logic        held;
    logic [15:0] frames;
  } fade_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  palette_fade_engine i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  fade_cmd_t    pending_cmds[$];
  fade_result_t expected_results[$];

  logic [7:0]  tgt_pal[256][3];
  logic [7:0]  cur_pal[256][3];
  logic        tgt_valid;
  logic        tgt_dirty;
  logic [15:0] frames_left;

  int  errors = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_off = 1'b0;
  bit  taken = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  recv_hold = 0;

  function automatic fade_result_t fade_predict(fade_cmd_t c);
    fade_result_t r;
    logic [7:0] comp[3];
    bit differ;
    int unsigned cu, tg, mag, step;
    r = '0;
    comp[0] = c.red;
    comp[1] = c.green;
    comp[2] = c.blue;
    case (c.command)
      CMD_WR_TARGET: begin
        for (int k = 0; k < 3; k++) begin
          if (tgt_pal[c.index][k] != comp[k]) begin
            tgt_pal[c.index][k] = comp[k];
            tgt_dirty = 1'b1;
          end
        end
      end
      CMD_WR_CURRENT: begin
        for (int k = 0; k < 3; k++) cur_pal[c.index][k] = comp[k];
      end
      CMD_COMMIT: begin
        if (!tgt_valid || tgt_dirty) begin
          frames_left = c.budget;
          tgt_valid = 1'b1;
          tgt_dirty = 1'b0;
        end
      end
      CMD_TICK: begin
        differ = 1'b0;
        for (int e = 0; e < 256; e++)
          for (int k = 0; k < 3; k++)
            if (cur_pal[e][k] != tgt_pal[e][k]) differ = 1'b1;
        if (tgt_valid && differ) begin
          if (frames_left == 0) begin
            cur_pal = tgt_pal;
          end else begin
            for (int e = 0; e < 256; e++) begin
              for (int k = 0; k < 3; k++) begin
                cu = cur_pal[e][k];
                tg = tgt_pal[e][k];
                if (cu != tg) begin
                  mag = (tg > cu) ? tg - cu : cu - tg;
                  step = (mag + frames_left - 1) / frames_left;
                  cur_pal[e][k] = 8'((tg > cu) ? cu + step : cu - step);
                end
              end
            end
            frames_left = frames_left - 1'b1;
          end
          r.changed = 1'b1;
        end
      end
      CMD_READ: begin
        r.red = cur_pal[c.index][0];
        r.green = cur_pal[c.index][1];
        r.blue = cur_pal[c.index][2];
      end
      default: ;
    endcase
    r.held = tgt_valid;
    r.frames = frames_left;
    return r;
  endfunction

  always @(negedge clk) begin
    if (s_tvalid && !taken) begin
      // Hold the offered transaction until it is taken.
    end else if (!rst && send_gap > 0) begin
      send_gap <= send_gap - 1;
      s_tvalid <= 1'b0;
    end else if (!rst && pending_cmds.size() > 0 && !(taken && !quiet &&
                 $urandom_range(0, 9) == 0)) begin
      s_tvalid <= 1'b1;
      s_tuser <= pending_cmds[0].command;
      s_tdata <= {pending_cmds[0].budget, pending_cmds[0].blue, pending_cmds[0].green,
                  pending_cmds[0].red, pending_cmds[0].index};
    end else begin
      s_tvalid <= 1'b0;
      if (!rst && !quiet && pending_cmds.size() > 0) send_gap <= $urandom_range(1, 6);
    end

    if (hold_off) begin
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    fade_result_t got, want;
    taken <= s_tvalid && s_tready;
    if (s_tvalid && s_tready) begin
      expected_results.push_back(fade_predict(pending_cmds.pop_front()));
    end
    if (m_tvalid && m_tready) begin
      got.red = m_tdata[7:0];
      got.green = m_tdata[15:8];
      got.blue = m_tdata[23:16];
      got.changed = m_tdata[24];
      got.held = m_tdata[25];
      got.frames = m_tdata[41:26];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
          begin
          $display("%0t: read colour expected %h %h %h actual %h %h %h", $time,
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
          errors++;
        end
        if (got.changed !== want.changed) begin
          $display("%0t: changed expected %b actual %b", $time, want.changed, got.changed);
          errors++;
        end
        if (got.held !== want.held) begin
          $display("%0t: held expected %b actual %b", $time, want.held, got.held);
          errors++;
        end
        if (got.frames !== want.frames) begin
          $display("%0t: frames expected %0d actual %0d", $time, want.frames, got.frames);
          errors++;
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("palette_fade_engine regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      if (recv_hold == 1) hold_off <= 1'b0;
    end
  end

  function automatic fade_cmd_t make_cmd(logic [2:0] op, int idx, int r, int g, int b,
                                         int bud);
    fade_cmd_t c;
    c.command = op;
    c.index = 8'(idx);
    c.red = 8'(r);
    c.green = 8'(g);
    c.blue = 8'(b);
    c.budget = 16'(bud);
    return c;
  endfunction

  function automatic fade_cmd_t random_cmd(int span);
    fade_cmd_t c;
    int pick;
    c = make_cmd(CMD_READ, $urandom_range(0, span), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255), 0);
    c.budget = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) :
                   $urandom_range(0, 8));
    pick = $urandom_range(0, 99);
    if (pick < 30) c.command = CMD_WR_TARGET;
    else if (pick < 45) c.command = CMD_WR_CURRENT;
    else if (pick < 55) c.command = CMD_COMMIT;
    else if (pick < 70) c.command = CMD_TICK;
    else if (pick < 97) c.command = CMD_READ;
    else c.command = 3'($urandom_range(5, 7));
    return c;
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    for (int e = 0; e < 256; e++)
      for (int k = 0; k < 3; k++) begin
        tgt_pal[e][k] = '0;
        cur_pal[e][k] = '0;
      end
    tgt_valid = 1'b0;
    tgt_dirty = 1'b0;
    frames_left = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    pending_cmds.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_COMMIT, 0, 0, 0, 0, 3));
    pending_cmds.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_WR_TARGET, 255, 255, 255, 255, 65535));
    pending_cmds.push_back(make_cmd(CMD_WR_TARGET, 0, 170, 85, 1, 0));
    pending_cmds.push_back(make_cmd(CMD_WR_CURRENT, 1, 255, 255, 255, 0));
    pending_cmds.push_back(make_cmd(CMD_COMMIT, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 255, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_COMMIT, 0, 0, 0, 0, 9));
    pending_cmds.push_back(make_cmd(CMD_WR_TARGET, 7, 200, 3, 99, 0));
    pending_cmds.push_back(make_cmd(CMD_COMMIT, 0, 0, 0, 0, 65535));
    pending_cmds.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 7, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_WR_TARGET, 7, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_COMMIT, 0, 0, 0, 0, 3));
    pending_cmds.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 7, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(3'd7, 255, 255, 255, 255, 65535));
    pending_cmds.push_back(make_cmd(3'd5, 0, 0, 0, 0, 0));
    drain();

    // The sink stalls for a long stretch while the source keeps offering transactions.
    for (int n = 0; n < 20; n++) pending_cmds.push_back(random_cmd(255));
    hold_off <= 1'b1;
    recv_hold <= 300;
    drain();

    for (int n = 0; n < 600; n++) begin
      if (n == 500) begin
        drain();
        quiet = 1'b1;
      end
      pending_cmds.push_back(random_cmd(($urandom_range(0, 3) == 0) ? 255 : 7));
      while (pending_cmds.size() > 8) @(posedge clk);
    end
    drain();

    if (errors == 0) begin
      $display("palette_fade_engine regression: pass");
    end else begin
      $display("palette_fade_engine regression: fail");
    end
    $finish;
  end

endmodule
